// ===== rtl/octave_bilinear_height_sampler_assert.svh =====
// ---------------------------------------------------------------------------
// octave bilinear height sampler assertion macros
// implication checks clocked on a rising edge, with async reset disable
// ---------------------------------------------------------------------------
`ifndef OCTAVE_BILINEAR_HEIGHT_SAMPLER_ASSERT_SVH
`define OCTAVE_BILINEAR_HEIGHT_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OBHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("obhs assertion failed");

// next-cycle implication
`define OBHS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("obhs assertion failed");

`else

`define OBHS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OBHS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/obhs_pkg.sv =====
// ---------------------------------------------------------------------------
// obhs_pkg
// shared widths, codes, control structs and elaboration helpers
// ---------------------------------------------------------------------------
`default_nettype none

package obhs_pkg;

	localparam int ADDR_W      = 17;
	localparam int VAL_W       = 16;
	localparam int COORD_W     = 32;
	localparam int SUM_W       = 19;
	localparam int CFG_W       = 4;
	localparam int PACK_W      = 4;
	localparam int SUM_ACC_W   = 21;
	localparam int TABLE_DEPTH = 131072;
	localparam int OUT_MAX     = 262143;
	localparam int OUT_MIN     = -262144;

	localparam logic [CFG_W-1:0] PACK_COUNT_RESET = 4'd2;

	// register index codes
	localparam logic REG_PACK_COUNT = 1'b0;

	// item function codes
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// per-beat control travelling down the pipeline
	typedef struct packed {
		logic              wr;
		logic              zero;
		logic              last;
		logic [1:0]        corner;
		logic [PACK_W-1:0] pack;
	} obhs_ctl_t;

	typedef struct packed {
		logic busy;
	} obhs_stat_t;

	// 2**e mod m by repeated doubling
	function automatic int obhs_pow2_mod(input int e, input int m);
		int r;
		r = 1;
		for (int i = 0; i < e; i++) begin
			r = r * 2;
			if (r >= m) r = r - m;
		end
		return r;
	endfunction

	// (n * c) mod m for c < m by repeated addition
	function automatic int obhs_mul_mod(input int n, input int c, input int m);
		int r;
		r = 0;
		for (int i = 0; i < n; i++) begin
			r = r + c;
			if (r >= m) r = r - m;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/obhs_in_if.sv =====
// ---------------------------------------------------------------------------
// obhs_in_if
// input item channel: table write or height sample request
// ---------------------------------------------------------------------------
`default_nettype none

interface obhs_in_if import obhs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [ADDR_W-1:0]         write_addr;
	logic signed [VAL_W-1:0]   write_value;
	logic signed [COORD_W-1:0] coord_u;
	logic signed [COORD_W-1:0] coord_v;

	modport source (output valid, func, write_addr, write_value, coord_u, coord_v,
		input ready);
	modport sink (input valid, func, write_addr, write_value, coord_u, coord_v,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/obhs_out_if.sv =====
// ---------------------------------------------------------------------------
// obhs_out_if
// result channel: summed height per sample
// ---------------------------------------------------------------------------
`default_nettype none

interface obhs_out_if import obhs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] height_sum;

	modport source (output valid, height_sum, input ready);
	modport sink (input valid, height_sum, output ready);
endinterface

`default_nettype wire

// ===== rtl/obhs_wrap.sv =====
// ---------------------------------------------------------------------------
// obhs_wrap
// two-stage floor modulo of a signed grid index, gives index and index+1
// ---------------------------------------------------------------------------
`default_nettype none

module obhs_wrap import obhs_pkg::*; #(
	parameter int GRID_SIZE = 128,
	parameter int IDX_W     = 20
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [IDX_W-1:0]             idx,
	output logic [$clog2(GRID_SIZE)-1:0]      lo_s3,
	output logic [$clog2(GRID_SIZE)-1:0]      hi_s3
);

	localparam int MW   = $clog2(GRID_SIZE);
	localparam int NN   = (IDX_W + 3) / 4;
	localparam int PADW = 4 * NN;
	localparam int SW   = MW + 3;
	localparam int CMOD = obhs_pow2_mod(IDX_W, GRID_SIZE);

	logic [MW-1:0]   tab_w [NN][16];
	logic [PADW-1:0] pad;
	logic [SW-1:0]   psum;
	logic [SW-1:0]   sum_s2;
	logic            neg_s2;
	logic [SW-1:0]   r;
	logic [MW-1:0]   lo;

	// per nibble residue tables: (n * 16**j) mod grid
	for (genvar j = 0; j < NN; j++) begin : g_nib
		for (genvar n = 0; n < 16; n++) begin : g_ent
			localparam int V = obhs_mul_mod(n, obhs_pow2_mod(4 * j, GRID_SIZE), GRID_SIZE);
			assign tab_w[j][n] = MW'(V);
		end
	end

	// sum of nibble residues
	assign pad = PADW'(idx);
	always_comb begin
		psum = '0;
		for (int j = 0; j < NN; j++) begin
			psum = psum + SW'(tab_w[j][pad[4*j +: 4]]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= psum;
			neg_s2 <= idx[IDX_W-1];
		end
	end

	// reduce below grid, then correct for the sign weight
	always_comb begin
		r = sum_s2;
		for (int i = 0; i < NN; i++) begin
			if (r >= SW'(GRID_SIZE)) r = r - SW'(GRID_SIZE);
		end
		if (neg_s2) begin
			r = r + SW'(GRID_SIZE - CMOD);
			if (r >= SW'(GRID_SIZE)) r = r - SW'(GRID_SIZE);
		end
		lo = MW'(r);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3 <= lo;
			hi_s3 <= (lo == MW'(GRID_SIZE - 1)) ? '0 : lo + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/obhs_front.sv =====
// ---------------------------------------------------------------------------
// obhs_front
// item intake, per-texel issue sequencer and table address stages s1..s4
// ---------------------------------------------------------------------------
`default_nettype none

module obhs_front import obhs_pkg::*; #(
	parameter int GRID_SIZE    = 128,
	parameter int FRAC_BITS    = 12,
	parameter int OCTAVE_SHIFT = 4,
	parameter int MAX_PACKS    = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic [CFG_W-1:0]     pack_count,
	obhs_in_if.sink                   item,
	output logic                      vld_s4,
	output obhs_ctl_t                 ctl_s4,
	output logic [ADDR_W-1:0]         addr_s4,
	output logic signed [VAL_W-1:0]   wdata_s4,
	output logic [FRAC_BITS-1:0]      fu_s4,
	output logic [FRAC_BITS-1:0]      fv_s4,
	output obhs_stat_t                stat
);

	localparam int IDX_W = COORD_W - FRAC_BITS;
	localparam int MW    = $clog2(GRID_SIZE);
	localparam int NW    = $clog2(MAX_PACKS + 1);
	localparam int SB    = (SAMPLE_BITS < VAL_W) ? SAMPLE_BITS : VAL_W;
	localparam int GG    = GRID_SIZE * GRID_SIZE;

	logic                    busy_q;
	logic [1:0]              corner_q;
	logic [PACK_W-1:0]       pack_q;
	logic [PACK_W-1:0]       last_pack_q;
	logic [COORD_W-1:0]      u_q;
	logic [COORD_W-1:0]      v_q;
	logic [NW-1:0]           n_cnt;
	logic                    accept;
	logic                    emit;
	logic signed [VAL_W-1:0] wval;

	logic                    vld_s1, vld_s2, vld_s3;
	obhs_ctl_t               ctl_s1, ctl_s2, ctl_s3;
	logic [IDX_W-1:0]        iu_s1, iv_s1;
	logic [FRAC_BITS-1:0]    fu_s1, fv_s1, fu_s2, fv_s2, fu_s3, fv_s3;
	logic [ADDR_W-1:0]       waddr_s1, waddr_s2, waddr_s3;
	logic signed [VAL_W-1:0] wdata_s1, wdata_s2, wdata_s3;
	logic [MW-1:0]           col_lo, col_hi, row_lo, row_hi;
	logic [MW-1:0]           col, row;
	logic [31:0]             taddr;

	// intake
	assign item.ready = en && !busy_q;
	assign accept     = item.valid && item.ready;
	assign stat.busy  = busy_q;

	always_comb begin
		if (int'(pack_count) > MAX_PACKS) n_cnt = NW'(MAX_PACKS);
		else n_cnt = NW'(pack_count);
	end

	assign emit = accept && !(item.func == FUNC_SAMPLE && n_cnt != '0);

	// stored texel keeps its low sample bits, sign-extended
	assign wval = (item.write_value <<< (VAL_W - SB)) >>> (VAL_W - SB);

	// sequencer and valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			corner_q    <= '0;
			pack_q      <= '0;
			last_pack_q <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			if (busy_q) begin
				vld_s1   <= 1'b1;
				corner_q <= corner_q + 2'd1;
				if (corner_q == 2'd3) begin
					if (pack_q == last_pack_q) busy_q <= 1'b0;
					else pack_q <= pack_q + 1'b1;
				end
			end else begin
				vld_s1 <= emit;
				if (accept && !emit) begin
					busy_q      <= 1'b1;
					corner_q    <= '0;
					pack_q      <= '0;
					last_pack_q <= PACK_W'(n_cnt) - 1'b1;
				end
			end
		end
	end

	// s1 payload and coordinate octave shift
	always_ff @(posedge clk) begin
		if (en) begin
			if (busy_q) begin
				ctl_s1.wr     <= 1'b0;
				ctl_s1.zero   <= 1'b0;
				ctl_s1.last   <= (pack_q == last_pack_q) && (corner_q == 2'd3);
				ctl_s1.corner <= corner_q;
				ctl_s1.pack   <= pack_q;
				iu_s1         <= u_q[COORD_W-1:FRAC_BITS];
				iv_s1         <= v_q[COORD_W-1:FRAC_BITS];
				fu_s1         <= u_q[FRAC_BITS-1:0];
				fv_s1         <= v_q[FRAC_BITS-1:0];
				if (corner_q == 2'd3) begin
					u_q <= u_q << OCTAVE_SHIFT;
					v_q <= v_q << OCTAVE_SHIFT;
				end
			end else if (accept) begin
				ctl_s1.wr     <= (item.func == FUNC_WRITE);
				ctl_s1.zero   <= 1'b1;
				ctl_s1.last   <= (item.func == FUNC_SAMPLE);
				ctl_s1.corner <= 2'd3;
				ctl_s1.pack   <= '0;
				waddr_s1      <= item.write_addr;
				wdata_s1      <= wval;
				u_q           <= item.coord_u;
				v_q           <= item.coord_v;
			end
		end
	end

	// grid wrap of column and row
	obhs_wrap #(.GRID_SIZE(GRID_SIZE), .IDX_W(IDX_W)) u_wrap_col (
		.clk   (clk),
		.en    (en),
		.idx   (iu_s1),
		.lo_s3 (col_lo),
		.hi_s3 (col_hi)
	);

	obhs_wrap #(.GRID_SIZE(GRID_SIZE), .IDX_W(IDX_W)) u_wrap_row (
		.clk   (clk),
		.en    (en),
		.idx   (iv_s1),
		.lo_s3 (row_lo),
		.hi_s3 (row_hi)
	);

	// carry payload alongside the wrap stages
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2   <= ctl_s1;
			fu_s2    <= fu_s1;
			fv_s2    <= fv_s1;
			waddr_s2 <= waddr_s1;
			wdata_s2 <= wdata_s1;
			ctl_s3   <= ctl_s2;
			fu_s3    <= fu_s2;
			fv_s3    <= fv_s2;
			waddr_s3 <= waddr_s2;
			wdata_s3 <= wdata_s2;
		end
	end

	// corner select and table address
	assign col   = ctl_s3.corner[0] ? col_hi : col_lo;
	assign row   = ctl_s3.corner[1] ? row_hi : row_lo;
	assign taddr = 32'(ctl_s3.pack) * 32'(GG) + 32'(row) * 32'(GRID_SIZE) + 32'(col);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4   <= ctl_s3;
			fu_s4    <= fu_s3;
			fv_s4    <= fv_s3;
			wdata_s4 <= wdata_s3;
			addr_s4  <= ctl_s3.wr ? waddr_s3 : taddr[ADDR_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/obhs_mem.sv =====
// ---------------------------------------------------------------------------
// obhs_mem
// texel table, one write or one registered read per cycle while enabled
// ---------------------------------------------------------------------------
`default_nettype none

module obhs_mem import obhs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [VAL_W-1:0]  wdata,
	output logic [VAL_W-1:0]       rdata_s5
);

	logic [VAL_W-1:0] mem_q [TABLE_DEPTH];

	// single port access, held while the pipeline stalls
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) mem_q[addr] <= wdata;
			else if (re) rdata_s5 <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/obhs_interp.sv =====
// ---------------------------------------------------------------------------
// obhs_interp
// bilinear weighting, octave accumulation, saturation and result register
// ---------------------------------------------------------------------------
`default_nettype none

module obhs_interp import obhs_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 vld_s4,
	input  wire obhs_ctl_t            ctl_s4,
	input  wire logic [FRAC_BITS-1:0] fu_s4,
	input  wire logic [FRAC_BITS-1:0] fv_s4,
	input  wire logic [VAL_W-1:0]     rdata_s5,
	output logic                      en,
	obhs_out_if.source                result
);

	localparam int W  = FRAC_BITS + 1;
	localparam int PW = VAL_W + W + 1;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

	logic                        vld_s5, vld_s6, vld_s7, vld_s8;
	obhs_ctl_t                   ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic [FRAC_BITS-1:0]        fu_s5, fv_s5, fv_s6, fv_s7;
	logic [W-1:0]                wh, wv;
	logic signed [PW-1:0]        prod_c, prod_s6, hacc_q;
	logic signed [PW:0]          hsum_c;
	logic signed [VAL_W-1:0]     rowv_s7;
	logic signed [PW-1:0]        vprod_c, vprod_s8, vacc_q;
	logic signed [PW:0]          vsum_c;
	logic signed [VAL_W-1:0]     packv_c;
	logic signed [SUM_ACC_W-1:0] sum_q, total_c;
	logic signed [SUM_W-1:0]     sat_c;
	logic                        fin_s8;
	logic                        out_vld_q;
	logic signed [SUM_W-1:0]     out_sum_q;

	// stall only when a finished result meets a full output register
	assign fin_s8 = vld_s8 && ctl_s8.last;
	assign en     = !(out_vld_q && !result.ready && fin_s8);

	// horizontal weight times texel
	assign wh     = ctl_s5.corner[0] ? {1'b0, fu_s5} : ONE - {1'b0, fu_s5};
	assign prod_c = $signed(rdata_s5) * $signed({1'b0, wh});

	// row interpolation
	assign hsum_c = (PW+1)'(hacc_q) + (PW+1)'(prod_s6);

	// vertical weight times row value
	assign wv      = ctl_s7.corner[1] ? {1'b0, fv_s7} : ONE - {1'b0, fv_s7};
	assign vprod_c = rowv_s7 * $signed({1'b0, wv});

	// pack value, running sum and saturation
	assign vsum_c  = (PW+1)'(vacc_q) + (PW+1)'(vprod_s8);
	assign packv_c = VAL_W'(vsum_c >>> FRAC_BITS);
	assign total_c = sum_q + SUM_ACC_W'(packv_c);

	always_comb begin
		if (ctl_s8.zero) sat_c = '0;
		else if (total_c > SUM_ACC_W'(OUT_MAX)) sat_c = SUM_W'(OUT_MAX);
		else if (total_c < SUM_ACC_W'(OUT_MIN)) sat_c = SUM_W'(OUT_MIN);
		else sat_c = SUM_W'(total_c);
	end

	// valid chain, running sum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			sum_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (en) begin
				vld_s5 <= vld_s4 && !ctl_s4.wr;
				vld_s6 <= vld_s5;
				vld_s7 <= vld_s6 && ctl_s6.corner[0];
				vld_s8 <= vld_s7;
				if (vld_s8 && ctl_s8.corner[1]) begin
					sum_q <= ctl_s8.last ? '0 : total_c;
				end
			end
			if (en && fin_s8) out_vld_q <= 1'b1;
			else if (result.ready) out_vld_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s5  <= ctl_s4;
			fu_s5   <= fu_s4;
			fv_s5   <= fv_s4;
			ctl_s6  <= ctl_s5;
			fv_s6   <= fv_s5;
			prod_s6 <= prod_c;
			if (vld_s6 && !ctl_s6.corner[0]) hacc_q <= prod_s6;
			ctl_s7  <= ctl_s6;
			fv_s7   <= fv_s6;
			rowv_s7 <= VAL_W'(hsum_c >>> FRAC_BITS);
			ctl_s8   <= ctl_s7;
			vprod_s8 <= vprod_c;
			if (vld_s8 && !ctl_s8.corner[1]) vacc_q <= vprod_s8;
			if (fin_s8) out_sum_q <= sat_c;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.height_sum = out_sum_q;

endmodule

`default_nettype wire

// ===== rtl/octave_bilinear_height_sampler.sv =====
// ---------------------------------------------------------------------------
// octave_bilinear_height_sampler: summed bilinear texel lookups over octave packs
// a sample with packs holds the issue sequencer, which blocks intake, and makes one table
// port read per texel; a write or zero-pack sample passes without holding it
// reset: pack_count 2, pipeline empty; the texel table is not cleared
// ---------------------------------------------------------------------------
`default_nettype none
`include "octave_bilinear_height_sampler_assert.svh"

module octave_bilinear_height_sampler import obhs_pkg::*; #(
	parameter int GRID_SIZE    = 128,
	parameter int FRAC_BITS    = 12,
	parameter int OCTAVE_SHIFT = 4,
	parameter int MAX_PACKS    = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	obhs_in_if.sink          item,
	obhs_out_if.source       result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic                    en;
	logic [CFG_W-1:0]        pack_count_q;
	obhs_stat_t              stat;
	logic                    vld_s4;
	obhs_ctl_t               ctl_s4;
	logic [ADDR_W-1:0]       addr_s4;
	logic signed [VAL_W-1:0] wdata_s4;
	logic [FRAC_BITS-1:0]    fu_s4, fv_s4;
	logic [VAL_W-1:0]        rdata_s5;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_count_q <= PACK_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PACK_COUNT) begin
			pack_count_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_PACK_COUNT) ? 32'(pack_count_q) : '0;

	// intake, sequencer and address stages
	obhs_front #(
		.GRID_SIZE    (GRID_SIZE),
		.FRAC_BITS    (FRAC_BITS),
		.OCTAVE_SHIFT (OCTAVE_SHIFT),
		.MAX_PACKS    (MAX_PACKS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.pack_count (pack_count_q),
		.item       (item),
		.vld_s4     (vld_s4),
		.ctl_s4     (ctl_s4),
		.addr_s4    (addr_s4),
		.wdata_s4   (wdata_s4),
		.fu_s4      (fu_s4),
		.fv_s4      (fv_s4),
		.stat       (stat)
	);

	// texel table
	obhs_mem u_mem (
		.clk      (clk),
		.en       (en),
		.we       (vld_s4 && ctl_s4.wr),
		.re       (vld_s4 && !ctl_s4.wr && !ctl_s4.zero),
		.addr     (addr_s4),
		.wdata    (wdata_s4),
		.rdata_s5 (rdata_s5)
	);

	// interpolation and accumulation
	obhs_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s4   (vld_s4),
		.ctl_s4   (ctl_s4),
		.fu_s4    (fu_s4),
		.fv_s4    (fv_s4),
		.rdata_s5 (rdata_s5),
		.en       (en),
		.result   (result)
	);

	// checks
	`OBHS_ASSERT_IMP(a_ready_not_busy, clk, arst_n, item.ready, !stat.busy)
	`OBHS_ASSERT_IMP(a_stall_blocks_intake, clk, arst_n, !en, !item.ready)
	`OBHS_ASSERT_NXT(a_write_single_beat, clk, arst_n, item.valid && item.ready && item.func == FUNC_WRITE, !stat.busy)

endmodule

`default_nettype wire
